/* rtl/wcpf_pkg.sv */
// Package: control word, datapath codes, microcode ROM and CRC helper for the framer.
`default_nettype none

package wcpf_pkg;

  localparam int unsigned PcW = 5;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  TIMEOUT_MAX = 8'd255;
  localparam logic [7:0]  END_MARK    = 8'h5A;

  // Program labels
  localparam logic [PcW-1:0] L_START      = 5'd0;
  localparam logic [PcW-1:0] L_KICK_BODY  = 5'd5;
  localparam logic [PcW-1:0] L_TAIL       = 5'd10;
  localparam logic [PcW-1:0] L_SETUP_BODY = 5'd13;
  localparam logic [PcW-1:0] L_LAST       = 5'd20;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_SEQ_LO,
    SRC_SEQ_HI,
    SRC_TMO,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_SETUP,
    JMP_ALWAYS
  } jmp_e;

  typedef struct packed {
    src_e           src;
    logic [7:0]     cbyte;
    logic           crc_en;
    logic           last;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ctrl_t;

  function automatic ctrl_t mk(src_e s, logic [7:0] b, logic c, logic l, jmp_e j,
                               logic [PcW-1:0] t);
    ctrl_t w;
    w.src = s; w.cbyte = b; w.crc_en = c; w.last = l; w.jmp = j; w.target = t;
    return w;
  endfunction

  // Header, sequence, branch to body, body, CRC, end mark.
  function automatic ctrl_t ucode_rom(logic [PcW-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:  w = mk(SRC_CONST,  8'hA5, 1'b0, 1'b0, JMP_NONE,   L_START);
      5'd1:  w = mk(SRC_CONST,  8'h01, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd2:  w = mk(SRC_CONST,  8'h81, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd3:  w = mk(SRC_SEQ_LO, 8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd4:  w = mk(SRC_SEQ_HI, 8'h00, 1'b1, 1'b0, JMP_SETUP,  L_SETUP_BODY);
      5'd5:  w = mk(SRC_CONST,  8'h03, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd6:  w = mk(SRC_CONST,  8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd7:  w = mk(SRC_CONST,  8'h01, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd8:  w = mk(SRC_CONST,  8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd9:  w = mk(SRC_CONST,  8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd10: w = mk(SRC_CRC_LO, 8'h00, 1'b0, 1'b0, JMP_NONE,   L_START);
      5'd11: w = mk(SRC_CRC_HI, 8'h00, 1'b0, 1'b0, JMP_NONE,   L_START);
      5'd12: w = mk(SRC_CONST,  END_MARK, 1'b0, 1'b1, JMP_NONE, L_START);
      5'd13: w = mk(SRC_CONST,  8'h06, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd14: w = mk(SRC_CONST,  8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd15: w = mk(SRC_CONST,  8'h13, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd16: w = mk(SRC_CONST,  8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd17: w = mk(SRC_CONST,  8'h3C, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd18: w = mk(SRC_CONST,  8'h3C, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd19: w = mk(SRC_TMO,    8'h00, 1'b1, 1'b0, JMP_NONE,   L_START);
      5'd20: w = mk(SRC_CONST,  8'h00, 1'b1, 1'b0, JMP_ALWAYS, L_TAIL);
      default: w = mk(SRC_CONST, END_MARK, 1'b0, 1'b1, JMP_NONE, L_START);
    endcase
    return w;
  endfunction

  // One byte of reflected CRC-16, eight shift steps.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* rtl/wcpf_if.sv */
// Interfaces: request channel and transmit byte channel.
`default_nettype none

interface wcpf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] timeout_seconds;
  modport source (output valid, req_type, timeout_seconds, input ready);
  modport sink   (input valid, req_type, timeout_seconds, output ready);
endinterface

interface wcpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/watchdog_command_packet_framer.sv */
// Top level: watchdog command packet framer with microcoded byte sequencer.
`default_nettype none

// Takes one watchdog request (kick or setup) and sends its framed packet one
// byte per transfer on the tx channel: 13 bytes for a kick, 16 for a setup.
// Each packet carries the header A5 01 81, the 16-bit sequence number low
// byte first (incremented after every packet, wrapping), the command body,
// a CRC-16/Modbus over byte 1 up to the byte before the CRC (low byte first)
// and the end mark 5A, flagged by last_byte. A setup timeout above 255 is
// saturated to 255. A short microcode program steps through the packet, one
// control word per byte, with a branch on the request type after the
// sequence bytes; the CRC is folded in a byte at a time as bytes are issued.
// Rate: one request per packet. With tx ready held high the packet goes out
// one byte per cycle; the next request is taken while the final byte still
// waits in the output register. Only one packet is in flight, since the
// program counter and CRC accumulator are shared.

module watchdog_command_packet_framer import wcpf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  wcpf_req_if.sink        req_i,
  wcpf_byte_if.source     tx_o
);

  logic           busy_q, busy_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q;
  logic           out_last_q;
  logic           start, adv, is_setup;
  logic [7:0]     dp_byte;
  logic [PcW-1:0] pc;
  ctrl_t          ctrl;

  // Take a request only between packets.
  assign req_i.ready = !busy_q;
  assign start       = req_i.valid && !busy_q;

  // Issue the next byte when the output register is free or being drained.
  assign adv = busy_q && (!out_valid_q || tx_o.ready);

  wcpf_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .adv_i      (adv),
    .is_setup_i (is_setup),
    .ctrl_o     (ctrl),
    .pc_o       (pc)
  );

  wcpf_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .timeout_i  (req_i.timeout_seconds),
    .adv_i      (adv),
    .ctrl_i     (ctrl),
    .byte_o     (dp_byte),
    .is_setup_o (is_setup)
  );

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = 1'b1;
      // Drop out of the packet once the end mark is issued.
      if (ctrl.last) begin
        busy_d = 1'b0;
      end
    end
    if (start) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the transfer completes.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= dp_byte;
      out_last_q <= ctrl.last;
    end
  end

  assign tx_o.valid     = out_valid_q;
  assign tx_o.tx_byte   = out_byte_q;
  assign tx_o.last_byte = out_last_q;

`ifndef ASSERT_OFF
  a_start_pc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> busy_q && pc == L_START)
    else $error("packet did not start at first step");

  a_last_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_o.valid && tx_o.last_byte |-> tx_o.tx_byte == END_MARK)
    else $error("last byte not end mark");

  a_pc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc <= L_LAST)
    else $error("program counter out of range");
`endif

endmodule

`default_nettype wire

/* rtl/wcpf_useq.sv */
// Microcode sequencer: step counter, control ROM and branch logic.
`default_nettype none

module wcpf_useq import wcpf_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           adv_i,
  input  wire logic           is_setup_i,
  output ctrl_t               ctrl_o,
  output logic    [PcW-1:0]   pc_o
);

  logic [PcW-1:0] pc_q, pc_d;

  assign ctrl_o = ucode_rom(pc_q);
  assign pc_o   = pc_q;

  always_comb begin
    pc_d = pc_q;
    if (start_i) begin
      pc_d = L_START;
    end else if (adv_i) begin
      case (ctrl_o.jmp)
        JMP_SETUP:  pc_d = is_setup_i ? ctrl_o.target : pc_q + PcW'(1);
        JMP_ALWAYS: pc_d = ctrl_o.target;
        default:    pc_d = pc_q + PcW'(1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= L_START;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/wcpf_dpath.sv */
// Datapath: sequence counter, request latch, CRC accumulator and byte select.
`default_nettype none

module wcpf_dpath import wcpf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        req_type_i,
  input  wire logic [15:0] timeout_i,
  input  wire logic        adv_i,
  input  wire ctrl_t       ctrl_i,
  output logic [7:0]       byte_o,
  output logic             is_setup_o
);

  logic [15:0] seq_q;
  logic [15:0] crc_q;
  logic [7:0]  tmo_q;
  logic        setup_q;

  assign is_setup_o = setup_q;

  always_comb begin
    case (ctrl_i.src)
      SRC_SEQ_LO: byte_o = seq_q[7:0];
      SRC_SEQ_HI: byte_o = seq_q[15:8];
      SRC_TMO:    byte_o = tmo_q;
      SRC_CRC_LO: byte_o = crc_q[7:0];
      SRC_CRC_HI: byte_o = crc_q[15:8];
      default:    byte_o = ctrl_i.cbyte;
    endcase
  end

  // Sequence number advances once per packet, after its high byte goes out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (adv_i && ctrl_i.src == SRC_SEQ_HI) begin
      seq_q <= seq_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      setup_q <= req_type_i;
      tmo_q   <= (|timeout_i[15:8]) ? TIMEOUT_MAX : timeout_i[7:0];
      crc_q   <= CRC_INIT;
    end else if (adv_i && ctrl_i.crc_en) begin
      crc_q   <= crc_byte(crc_q, byte_o);
    end
  end

endmodule

`default_nettype wire
